// File: design/brt_pkg.sv
`default_nettype none

package brt_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_GLYPH_STORE_BYTES = 8192;
  localparam int DEF_MAX_GLYPH_ROWS    = 16;
  localparam int DEF_MAX_COLUMN_GROUPS = 2;

  // Wide enough for char * bytes_per_char + group offset + row
  localparam int IDX_W = 16;
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [7:0]  RST_FIRST_CHAR     = 8'd0;
  localparam logic [7:0]  RST_LAST_CHAR      = 8'd255;
  localparam logic [4:0]  RST_GLYPH_WIDTH    = 5'd8;
  localparam logic [4:0]  RST_GLYPH_HEIGHT   = 5'd16;
  localparam logic [5:0]  RST_BYTES_PER_CHAR = 6'd16;
  localparam logic [11:0] RST_SURFACE_WIDTH  = 12'd640;
  localparam logic [11:0] RST_SURFACE_HEIGHT = 12'd480;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_CHAR  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_CHAR     = 3'd0,
    CFG_LAST_CHAR      = 3'd1,
    CFG_GLYPH_WIDTH    = 3'd2,
    CFG_GLYPH_HEIGHT   = 3'd3,
    CFG_BYTES_PER_CHAR = 3'd4,
    CFG_SURFACE_WIDTH  = 3'd5,
    CFG_SURFACE_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT,
    ST_ADVANCE,
    ST_WRAP
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] glyph_address;
    logic [7:0]  glyph_byte;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [23:0] color;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [7:0]  pixel_mask;
    logic [23:0] pixel_color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load_glyph;
    logic start_text;
    logic latch_char;
    logic init_loop;
    logic issue;
    logic advance_x;
    logic line_adv;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic newline;
    logic draw_ok;
    logic wrap;
    logic loop_end;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// File: design/bitmap_text_renderer.sv
// Bitmap text renderer.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one item at a time:
// a glyph byte load, a text start (origin, colour, cursor) or a character.
// Output channel (out_valid_o/out_ready_i, out_data_o) gives 8-pixel row
// writes: x, y, mask (bit 7 leftmost) and colour, with last on the final
// write of a character. Configuration is a plain write port (cfg_we_i,
// cfg_index_i, cfg_data_i), to be written only while the block is idle;
// the block does not enforce this. A drawn character is set up, then gives
// groups*rows writes at one per cycle while the receiver takes them, then
// moves the cursor and, on a wrap, to a new line; the single read port of
// the glyph store sets the one write per cycle. Newlines go to a new line;
// skipped codes still move the cursor. The last write of a character may
// still wait in the output register while the next item is taken. A
// stalled receiver holds the write walk, one write held.
// Reset clears configuration to defaults, cursor, colour and halt; the
// glyph store is not cleared and must be loaded before it is drawn from.
`default_nettype none

module bitmap_text_renderer #(
  parameter int GLYPH_STORE_BYTES = brt_pkg::DEF_GLYPH_STORE_BYTES,
  parameter int MAX_GLYPH_ROWS    = brt_pkg::DEF_MAX_GLYPH_ROWS,
  parameter int MAX_COLUMN_GROUPS = brt_pkg::DEF_MAX_COLUMN_GROUPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  brt_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output brt_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [brt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [brt_pkg::CFG_W-1:0]     cfg_data_i
);
  import brt_pkg::*;

  cmd_t    cmd;
  status_t sts;

  brt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_op_i    (in_data_i.op),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brt_datapath #(
    .GLYPH_STORE_BYTES (GLYPH_STORE_BYTES),
    .MAX_GLYPH_ROWS    (MAX_GLYPH_ROWS),
    .MAX_COLUMN_GROUPS (MAX_COLUMN_GROUPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // a write is never issued over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> (!out_valid_o || out_ready_i))
    else $error("write issued over a pending write");

  // no item is taken while a glyph is being walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !in_ready_o)
    else $error("input ready during glyph walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_glyph, cmd.start_text, cmd.latch_char, cmd.init_loop,
              cmd.issue, cmd.advance_x, cmd.line_adv}))
    else $error("more than one datapath command at once");

  // an issued write shows up on the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |=> out_valid_o)
    else $error("issued write not presented");
`endif

endmodule

`default_nettype wire

// File: design/brt_ctrl.sv
`default_nettype none

module brt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_op_i,
  input  brt_pkg::status_t sts_i,
  output brt_pkg::cmd_t   cmd_o
);
  import brt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            OP_LOAD:  cmd_o.load_glyph = 1'b1;
            OP_START: cmd_o.start_text = 1'b1;
            OP_CHAR: begin
              // halted drops character items, newlines too
              if (!sts_i.halted) begin
                cmd_o.latch_char = 1'b1;
                state_d          = ST_SETUP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        if (sts_i.newline) begin
          cmd_o.line_adv = 1'b1;
          state_d        = ST_IDLE;
        end else if (sts_i.draw_ok) begin
          cmd_o.init_loop = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          state_d = ST_ADVANCE;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.issue = 1'b1;
          if (sts_i.loop_end) begin
            state_d = ST_ADVANCE;
          end
        end
      end
      ST_ADVANCE: begin
        cmd_o.advance_x = 1'b1;
        state_d         = sts_i.wrap ? ST_WRAP : ST_IDLE;
      end
      ST_WRAP: begin
        cmd_o.line_adv = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: design/brt_datapath.sv
`default_nettype none

module brt_datapath #(
  parameter int GLYPH_STORE_BYTES = brt_pkg::DEF_GLYPH_STORE_BYTES,
  parameter int MAX_GLYPH_ROWS    = brt_pkg::DEF_MAX_GLYPH_ROWS,
  parameter int MAX_COLUMN_GROUPS = brt_pkg::DEF_MAX_COLUMN_GROUPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brt_pkg::in_item_t             in_data_i,
  input  logic                          cfg_we_i,
  input  logic [brt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [brt_pkg::CFG_W-1:0]     cfg_data_i,
  input  brt_pkg::cmd_t                 cmd_i,
  output brt_pkg::status_t              sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output brt_pkg::out_item_t            out_data_o
);
  import brt_pkg::*;

  // Store size is taken as a power of two; indexes wrap at its size
  localparam int AW  = $clog2(GLYPH_STORE_BYTES);
  localparam int GW  = (MAX_COLUMN_GROUPS > 1) ? $clog2(MAX_COLUMN_GROUPS) : 1;
  localparam int RW  = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
  localparam int GLW = $clog2(MAX_COLUMN_GROUPS + 1);
  localparam int RLW = $clog2(MAX_GLYPH_ROWS + 1);

  // configuration
  logic [7:0]  first_char_q, last_char_q;
  logic [4:0]  glyph_width_q, glyph_height_q;
  logic [5:0]  bytes_per_char_q;
  logic [11:0] surface_width_q, surface_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_char_q     <= RST_FIRST_CHAR;
      last_char_q      <= RST_LAST_CHAR;
      glyph_width_q    <= RST_GLYPH_WIDTH;
      glyph_height_q   <= RST_GLYPH_HEIGHT;
      bytes_per_char_q <= RST_BYTES_PER_CHAR;
      surface_width_q  <= RST_SURFACE_WIDTH;
      surface_height_q <= RST_SURFACE_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FIRST_CHAR:     first_char_q     <= cfg_data_i[7:0];
        CFG_LAST_CHAR:      last_char_q      <= cfg_data_i[7:0];
        CFG_GLYPH_WIDTH:    glyph_width_q    <= cfg_data_i[4:0];
        CFG_GLYPH_HEIGHT:   glyph_height_q   <= cfg_data_i[4:0];
        CFG_BYTES_PER_CHAR: bytes_per_char_q <= cfg_data_i[5:0];
        CFG_SURFACE_WIDTH:  surface_width_q  <= cfg_data_i;
        CFG_SURFACE_HEIGHT: surface_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // text state
  logic [12:0] cursor_x_q, cursor_y_q;
  logic [11:0] text_origin_x_q;
  logic [23:0] draw_color_q;
  logic        halted_q;
  logic [12:0] next_x, next_y;

  assign next_x = cursor_x_q + 13'(glyph_width_q);
  assign next_y = cursor_y_q + 13'(glyph_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q      <= '0;
      cursor_y_q      <= '0;
      text_origin_x_q <= '0;
      draw_color_q    <= '0;
      halted_q        <= 1'b0;
    end else if (cmd_i.start_text) begin
      text_origin_x_q <= in_data_i.origin_x;
      cursor_x_q      <= 13'(in_data_i.origin_x);
      cursor_y_q      <= 13'(in_data_i.origin_y);
      draw_color_q    <= in_data_i.color;
      halted_q        <= 1'b0;
    end else if (cmd_i.line_adv) begin
      cursor_x_q <= 13'(text_origin_x_q);
      cursor_y_q <= next_y;
      halted_q   <= next_y > {1'b0, surface_height_q};
    end else if (cmd_i.advance_x) begin
      cursor_x_q <= next_x;
    end
  end

  // glyph walk: group outer, row inner
  logic [7:0]       char_q;
  logic [IDX_W-1:0] base_q, goff_q;
  logic [GW-1:0]    grp_q;
  logic [RW-1:0]    row_q;
  logic [13:0]      char_base;
  logic [2:0]       grp_raw;
  logic [GLW-1:0]   grp_lim;
  logic [RLW-1:0]   row_lim;
  logic             last_row, last_grp;

  assign char_base = 14'(char_q) * 14'(bytes_per_char_q);
  assign grp_raw   = 3'((6'(glyph_width_q) + 6'd7) >> 3);
  assign grp_lim   = (32'(grp_raw) > MAX_COLUMN_GROUPS) ? GLW'(MAX_COLUMN_GROUPS)
                                                        : GLW'(grp_raw);
  assign row_lim   = (32'(glyph_height_q) > MAX_GLYPH_ROWS) ? RLW'(MAX_GLYPH_ROWS)
                                                            : RLW'(glyph_height_q);
  assign last_row  = (RLW'(row_q) + RLW'(1)) == row_lim;
  assign last_grp  = (GLW'(grp_q) + GLW'(1)) == grp_lim;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_char) begin
      char_q <= in_data_i.char_code;
    end
    if (cmd_i.init_loop) begin
      base_q <= IDX_W'(char_base);
      goff_q <= '0;
      grp_q  <= '0;
      row_q  <= '0;
    end else if (cmd_i.issue) begin
      if (last_row) begin
        row_q  <= '0;
        grp_q  <= grp_q + GW'(1);
        goff_q <= goff_q + IDX_W'(glyph_height_q);
      end else begin
        row_q <= row_q + RW'(1);
      end
    end
  end

  // glyph store, one port: loads only happen while no glyph is walked
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [7:0]       glyph_mem_q [GLYPH_STORE_BYTES];
  logic [7:0]       mask_q;

  assign rd_idx  = base_q + goff_q + IDX_W'(row_q);
  assign rd_addr = rd_idx[AW-1:0];
  assign wr_idx  = IDX_W'(in_data_i.glyph_address);
  assign wr_addr = wr_idx[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_glyph) begin
      glyph_mem_q[wr_addr] <= in_data_i.glyph_byte;
    end
    if (cmd_i.issue) begin
      mask_q <= glyph_mem_q[rd_addr];
    end
  end

  // output register, loaded alongside the store read
  logic        out_valid_q;
  logic [12:0] pix_x_q, pix_y_q;
  logic [23:0] pix_color_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.issue) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      pix_x_q     <= cursor_x_q + 13'({grp_q, 3'b000});
      pix_y_q     <= cursor_y_q + 13'(row_q);
      pix_color_q <= draw_color_q;
      last_q      <= last_row && last_grp;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.pixel_x     = pix_x_q;
  assign out_data_o.pixel_y     = pix_y_q;
  assign out_data_o.pixel_mask  = mask_q;
  assign out_data_o.pixel_color = pix_color_q;
  assign out_data_o.last        = last_q;

  assign sts_o.halted   = halted_q;
  assign sts_o.newline  = char_q == NEWLINE_CODE;
  assign sts_o.draw_ok  = (char_q >= first_char_q) && (char_q <= last_char_q) &&
                          (glyph_width_q != '0) && (glyph_height_q != '0);
  assign sts_o.wrap     = next_x > {1'b0, surface_width_q};
  assign sts_o.loop_end = last_row && last_grp;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

// File: sim/bitmap_text_renderer_checker.sv
module bitmap_text_renderer_checker #(
  parameter int GLYPH_STORE_BYTES = brt_pkg::DEF_GLYPH_STORE_BYTES,
  parameter int MAX_GLYPH_ROWS    = brt_pkg::DEF_MAX_GLYPH_ROWS,
  parameter int MAX_COLUMN_GROUPS = brt_pkg::DEF_MAX_COLUMN_GROUPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  brt_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  brt_pkg::out_item_t            out_data_i,
  input  logic                          cfg_we_i,
  input  logic [brt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [brt_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            writes_due_o,
  output int                            writes_checked_o
);
  import brt_pkg::*;

  logic [7:0]  glyph_mem [GLYPH_STORE_BYTES];
  logic [7:0]  first_code;
  logic [7:0]  last_code;
  logic [4:0]  cell_w;
  logic [4:0]  cell_h;
  logic [5:0]  char_stride;
  logic [11:0] surf_w;
  logic [11:0] surf_h;
  logic [12:0] pen_x;
  logic [12:0] pen_y;
  logic [11:0] margin_x;
  logic [23:0] ink;
  logic        halted;
  out_item_t   writes_due [$];
  out_item_t   want;
  int          fails = 0;
  int          checked = 0;

  task automatic line_feed();
    pen_x = {1'b0, margin_x};
    pen_y = pen_y + 13'(cell_h);
    if (pen_y > {1'b0, surf_h}) halted = 1'b1;
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    case (idx)
      CFG_FIRST_CHAR:     first_code  = value[7:0];
      CFG_LAST_CHAR:      last_code   = value[7:0];
      CFG_GLYPH_WIDTH:    cell_w      = value[4:0];
      CFG_GLYPH_HEIGHT:   cell_h      = value[4:0];
      CFG_BYTES_PER_CHAR: char_stride = value[5:0];
      CFG_SURFACE_WIDTH:  surf_w      = value;
      CFG_SURFACE_HEIGHT: surf_h      = value;
      default: ;
    endcase
  endtask

  // Works out the row writes one accepted item causes and moves the cursor.
  task automatic render_item(input in_item_t it);
    int        groups;
    int        rows;
    int        idx;
    out_item_t w;
    case (it.op)
      OP_LOAD: glyph_mem[int'(it.glyph_address) % GLYPH_STORE_BYTES] = it.glyph_byte;
      OP_START: begin
        margin_x = it.origin_x;
        pen_x    = {1'b0, it.origin_x};
        pen_y    = {1'b0, it.origin_y};
        ink      = it.color;
        halted   = 1'b0;
      end
      OP_CHAR: if (!halted) begin
        if (it.char_code == NEWLINE_CODE) begin
          line_feed();
        end else begin
          if (it.char_code >= first_code && it.char_code <= last_code &&
              cell_w != 0 && cell_h != 0) begin
            groups = (int'(cell_w) + 7) >> 3;
            if (groups > MAX_COLUMN_GROUPS) groups = MAX_COLUMN_GROUPS;
            rows = (int'(cell_h) > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : int'(cell_h);
            for (int g = 0; g < groups; g++) begin
              for (int r = 0; r < rows; r++) begin
                // group stride is the full height, even when rows are clipped
                idx = (int'(it.char_code) * int'(char_stride) + g * int'(cell_h) + r)
                      % GLYPH_STORE_BYTES;
                w.pixel_x     = pen_x + 13'(8 * g);
                w.pixel_y     = pen_y + 13'(r);
                w.pixel_mask  = glyph_mem[idx];
                w.pixel_color = ink;
                w.last        = (g == groups - 1) && (r == rows - 1);
                writes_due.push_back(w);
              end
            end
          end
          // skipped codes still move the cursor
          pen_x = pen_x + 13'(cell_w);
          if (pen_x > {1'b0, surf_w}) line_feed();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_code  = RST_FIRST_CHAR;
      last_code   = RST_LAST_CHAR;
      cell_w      = RST_GLYPH_WIDTH;
      cell_h      = RST_GLYPH_HEIGHT;
      char_stride = RST_BYTES_PER_CHAR;
      surf_w      = RST_SURFACE_WIDTH;
      surf_h      = RST_SURFACE_HEIGHT;
      pen_x       = '0;
      pen_y       = '0;
      margin_x    = '0;
      ink         = '0;
      halted      = 1'b0;
      writes_due.delete();
    end else begin
      if (cfg_we_i) set_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) render_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (writes_due.size() == 0) begin
          $error("unexpected pixel write x=%0d y=%0d mask=%02h",
                 out_data_i.pixel_x, out_data_i.pixel_y, out_data_i.pixel_mask);
          fails++;
        end else begin
          want = writes_due.pop_front();
          if (want.pixel_x !== out_data_i.pixel_x) begin
            $error("pixel_x: expected %0d, actual %0d", want.pixel_x, out_data_i.pixel_x);
            fails++;
          end
          if (want.pixel_y !== out_data_i.pixel_y) begin
            $error("pixel_y: expected %0d, actual %0d", want.pixel_y, out_data_i.pixel_y);
            fails++;
          end
          if (want.pixel_mask !== out_data_i.pixel_mask) begin
            $error("pixel_mask: expected %02h, actual %02h",
                   want.pixel_mask, out_data_i.pixel_mask);
            fails++;
          end
          if (want.pixel_color !== out_data_i.pixel_color) begin
            $error("pixel_color: expected %06h, actual %06h",
                   want.pixel_color, out_data_i.pixel_color);
            fails++;
          end
          if (want.last !== out_data_i.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_data_i.last);
            fails++;
          end
        end
      end
    end
    fail_count_o     <= fails;
    writes_due_o     <= writes_due.size();
    writes_checked_o <= checked;
  end

endmodule

// File: sim/bitmap_text_renderer_tb.sv
module bitmap_text_renderer_tb;
  import brt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 310;
  localparam int PHASE_STEPS   = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int STORE_BYTES   = DEF_GLYPH_STORE_BYTES;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   writes_due;
  int                   writes_checked;

  // settings as last written, so that drawn glyphs are always loaded first
  logic [7:0]  lo_code = RST_FIRST_CHAR;
  logic [7:0]  hi_code = RST_LAST_CHAR;
  logic [4:0]  cell_w = RST_GLYPH_WIDTH;
  logic [4:0]  cell_h = RST_GLYPH_HEIGHT;
  logic [5:0]  stride = RST_BYTES_PER_CHAR;
  logic [11:0] surf_w = RST_SURFACE_WIDTH;
  logic [11:0] surf_h = RST_SURFACE_HEIGHT;
  bit          glyph_loaded [STORE_BYTES];
  int          items_sent = 0;
  int          loads_sent = 0;
  int          phases_run = 0;
  int          cycle = 0;
  int          hold_left = 0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;

  always #5 clk = ~clk;

  bitmap_text_renderer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  bitmap_text_renderer_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .writes_due_o     (writes_due),
    .writes_checked_o (writes_checked)
  );

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, and a calm stretch
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      out_ready    <= 1'b0;
    end else if (writes_checked >= 400 && writes_checked < 800) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 6);
    end
  end

  function automatic in_item_t scrambled_item();
    in_item_t it;
    it.op            = OP_UNUSED;
    it.glyph_address = 13'($urandom);
    it.glyph_byte    = 8'($urandom);
    it.origin_x      = 12'($urandom);
    it.origin_y      = 12'($urandom);
    it.color         = 24'($urandom);
    it.char_code     = 8'($urandom);
    return it;
  endfunction

  task automatic push_item(input in_item_t it);
    if (!(items_sent >= 150 && items_sent < 230)) begin
      while ($urandom_range(99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.op != OP_UNUSED) items_sent++;
    if (it.op == OP_LOAD) loads_sent++;
  endtask

  task automatic send_load(input logic [12:0] addr, input logic [7:0] value);
    in_item_t it;
    it               = scrambled_item();
    it.op            = OP_LOAD;
    it.glyph_address = addr;
    it.glyph_byte    = value;
    glyph_loaded[int'(addr) % STORE_BYTES] = 1'b1;
    push_item(it);
  endtask

  task automatic send_start(input logic [11:0] x, input logic [11:0] y,
                            input logic [23:0] colour);
    in_item_t it;
    it          = scrambled_item();
    it.op       = OP_START;
    it.origin_x = x;
    it.origin_y = y;
    it.color    = colour;
    push_item(it);
  endtask

  task automatic random_start();
    logic [11:0] x;
    logic [11:0] y;
    x = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(int'(surf_w)));
    y = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(int'(surf_h)));
    send_start(x, y, 24'($urandom));
  endtask

  // a drawn code reads its glyph bytes, so any that were never loaded go in first
  task automatic send_char(input logic [7:0] code);
    in_item_t it;
    int       groups;
    int       rows;
    int       idx;
    if (code != NEWLINE_CODE && code >= lo_code && code <= hi_code &&
        cell_w != 0 && cell_h != 0) begin
      groups = (int'(cell_w) + 7) >> 3;
      if (groups > DEF_MAX_COLUMN_GROUPS) groups = DEF_MAX_COLUMN_GROUPS;
      rows = (int'(cell_h) > DEF_MAX_GLYPH_ROWS) ? DEF_MAX_GLYPH_ROWS : int'(cell_h);
      for (int g = 0; g < groups; g++) begin
        for (int r = 0; r < rows; r++) begin
          idx = (int'(code) * int'(stride) + g * int'(cell_h) + r) % STORE_BYTES;
          if (!glyph_loaded[idx]) send_load(13'(idx), 8'($urandom));
        end
      end
    end
    it           = scrambled_item();
    it.op        = OP_CHAR;
    it.char_code = code;
    push_item(it);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] lo, input logic [7:0] hi,
                                input logic [4:0] w, input logic [4:0] h,
                                input logic [5:0] bytes, input logic [11:0] sw,
                                input logic [11:0] sh);
    put_reg(CFG_FIRST_CHAR, CFG_W'(lo));
    put_reg(CFG_LAST_CHAR, CFG_W'(hi));
    put_reg(CFG_GLYPH_WIDTH, CFG_W'(w));
    put_reg(CFG_GLYPH_HEIGHT, CFG_W'(h));
    put_reg(CFG_BYTES_PER_CHAR, CFG_W'(bytes));
    put_reg(CFG_SURFACE_WIDTH, sw);
    put_reg(CFG_SURFACE_HEIGHT, sh);
    cfg_we  <= 1'b0;
    lo_code = lo;
    hi_code = hi;
    cell_w  = w;
    cell_h  = h;
    stride  = bytes;
    surf_w  = sw;
    surf_h  = sh;
    phases_run++;
  endtask

  // skipped codes give no write, so the drain also waits a settling time after the last one
  task automatic drain_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (writes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int p);
    logic [7:0]  pool [3];
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [4:0]  w;
    logic [4:0]  h;
    logic [5:0]  bytes;
    logic [11:0] sw;
    logic [11:0] sh;
    int          pick;
    case (p)
      0: apply_settings(8'd32, 8'd126, 5'd6, 5'd8, 6'd8, 12'd100, 12'd60);
      1: apply_settings(8'd0, 8'd255, 5'd16, 5'd16, 6'd32, 12'd4095, 12'd4095);
      2: apply_settings(8'd0, 8'd255, 5'd0, 5'd5, 6'd4, 12'd50, 12'd4095);
      3: apply_settings(8'd65, 8'd65, 5'd5, 5'd3, 6'd0, 12'd0, 12'd0);
      4: apply_settings(8'd255, 8'd0, 5'd0, 5'd0, 6'd32, 12'd4095, 12'd0);
      // wider and taller than the block draws
      5: apply_settings(8'd0, 8'd255, 5'd24, 5'd20, 6'd32, 12'd300, 12'd200);
      default: begin
        lo    = 8'($urandom_range(127));
        hi    = 8'($urandom_range(255, int'(lo)));
        w     = 5'($urandom_range(16, 1));
        h     = 5'($urandom_range(10, 1));
        bytes = 6'($urandom_range(32));
        sw    = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(200, 16));
        sh    = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(150, 8));
        apply_settings(lo, hi, w, h, bytes, sw, sh);
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      pool[i] = (lo_code <= hi_code) ? 8'($urandom_range(int'(hi_code), int'(lo_code)))
                                     : 8'($urandom);
    end
    random_start();
    // long receiver hold-off while large glyphs keep coming
    if (p == 1) squeeze_req = 1'b1;
    for (int s = 0; s < PHASE_STEPS; s++) begin
      pick = $urandom_range(99);
      if (pick < 10) random_start();
      else if (pick < 20) send_char(NEWLINE_CODE);
      else if (pick < 28) send_char(8'($urandom));
      else if (pick < 32) push_item(scrambled_item());
      else if (pick < 37) send_load(13'($urandom), 8'($urandom));
      else send_char(pool[$urandom_range(2)]);
    end
    drain_writes();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two-group glyph, two rows, narrow and short surface
    apply_settings(8'd5, 8'd200, 5'd9, 5'd2, 6'd4, 12'd40, 12'd4);
    push_item('1);
    send_load(13'd20, 8'hFF);
    send_load(13'd21, 8'h00);
    send_load(13'd22, 8'h80);
    send_load(13'd23, 8'h01);
    send_start(12'd0, 12'd0, 24'hFFFFFF);
    send_char(8'd5);
    send_char(8'd0);
    send_char(8'd255);
    send_char(8'd5);
    send_char(8'd5);        // passes the width: wraps
    send_char(NEWLINE_CODE);
    send_char(8'd5);
    send_char(NEWLINE_CODE); // past the height: halts
    send_char(8'd5);
    send_start(12'hFFF, 12'hFFF, 24'h000000);
    send_char(8'd5);        // origin already below the surface
    send_char(NEWLINE_CODE);
    send_start(12'd7, 12'd1, 24'($urandom));
    send_char(8'd200);
    drain_writes();

    for (int p = 0; items_sent < RANDOM_ITEMS; p++) run_phase(p);
    repeat (20) @(posedge clk);

    $display("summary: %0d items (%0d glyph loads) under %0d register settings",
             items_sent, loads_sent, phases_run);
    $display("summary: %0d pixel writes checked, %0d mismatches, %0d writes outstanding",
             writes_checked, fail_count, writes_due);
    if (fail_count == 0 && writes_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: bitmap_text_renderer.f
design/brt_pkg.sv
design/brt_ctrl.sv
design/brt_datapath.sv
design/bitmap_text_renderer.sv
sim/bitmap_text_renderer_checker.sv
sim/bitmap_text_renderer_tb.sv
